@@ hdl/gad_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Global alignment distance: shared package
// Types, codes and default sizes used across the alignment core.
// ----------------------------------------------------------------------------
package gad_pkg;

   // Default longest reference or query, in symbols.
   localparam int MAX_LEN_DEF = 256;

   // Fixed field widths.
   localparam int DIST_W = 10;
   localparam int SYM_W  = 8;
   localparam int GAP_W  = 8;
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   // Traceback move codes.
   localparam logic [1:0] MV_DIAG = 2'd0;
   localparam logic [1:0] MV_UP   = 2'd1;
   localparam logic [1:0] MV_LEFT = 2'd2;

   // Input beat commands.
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // Register indexes (byte address divided by four).
   localparam logic [1:0] REG_NO_END_GAP = 2'd0;
   localparam logic [1:0] REG_GAP_OPEN   = 2'd1;
   localparam logic [1:0] REG_GAP_EXTEND = 2'd2;

   typedef struct packed {
      logic                    no_end_gap;
      logic signed [GAP_W-1:0] gap_open;
      logic signed [GAP_W-1:0] gap_extend;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      logic [DIST_W-1:0] distance;
      logic              overflow;
   } result_type;

endpackage

@@ hdl/gad_csr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Global alignment distance: configuration registers
// Holds the end-gap mode and the two gap scores behind a simple APB port.
// ----------------------------------------------------------------------------
module gad_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [gad_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [gad_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [gad_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                         csr_pready,
   output gad_pkg::cfg_type             cfg
);

   gad_pkg::cfg_type cfg_ff;
   gad_pkg::cfg_type cfg_in;
   logic             wr_en;
   logic [1:0]       reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[3:2];
   assign cfg        = cfg_ff;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            gad_pkg::REG_NO_END_GAP: cfg_in.no_end_gap = csr_pwdata[0];
            gad_pkg::REG_GAP_OPEN:   cfg_in.gap_open   = csr_pwdata[gad_pkg::GAP_W-1:0];
            gad_pkg::REG_GAP_EXTEND: cfg_in.gap_extend = csr_pwdata[gad_pkg::GAP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.no_end_gap <= 1'b0;
         cfg_ff.gap_open   <= '1;
         cfg_ff.gap_extend <= '1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back, gap scores sign extended.
   always_comb begin
      case (reg_idx)
         gad_pkg::REG_NO_END_GAP:
            csr_prdata = {{(gad_pkg::CSR_DW-1){1'b0}}, cfg_ff.no_end_gap};
         gad_pkg::REG_GAP_OPEN:
            csr_prdata = {{(gad_pkg::CSR_DW-gad_pkg::GAP_W){cfg_ff.gap_open[gad_pkg::GAP_W-1]}},
                          cfg_ff.gap_open};
         gad_pkg::REG_GAP_EXTEND:
            csr_prdata = {{(gad_pkg::CSR_DW-gad_pkg::GAP_W){cfg_ff.gap_extend[gad_pkg::GAP_W-1]}},
                          cfg_ff.gap_extend};
         default: csr_prdata = '0;
      endcase
   end

endmodule

@@ hdl/gad_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Global alignment distance: matrix cell
// Scores the diagonal, up and left moves of one cell and picks the winner.
// ----------------------------------------------------------------------------
module gad_cell #(
   parameter int SCORE_W = 18
) (
   input  logic signed [SCORE_W-1:0]        diag_s,
   input  logic [gad_pkg::DIST_W-1:0]       diag_d,
   input  logic signed [SCORE_W-1:0]        up_s,
   input  logic [1:0]                       up_m,
   input  logic [gad_pkg::DIST_W-1:0]       up_d,
   input  logic signed [SCORE_W-1:0]        left_s,
   input  logic [1:0]                       left_m,
   input  logic [gad_pkg::DIST_W-1:0]       left_d,
   input  logic                             same,
   input  logic                             gap_count,
   input  logic signed [gad_pkg::GAP_W-1:0] gap_open,
   input  logic signed [gad_pkg::GAP_W-1:0] gap_extend,
   output logic signed [SCORE_W-1:0]        new_s,
   output logic [1:0]                       new_m,
   output logic [gad_pkg::DIST_W-1:0]       new_d
);

   localparam int GW = gad_pkg::GAP_W;
   localparam int DW = gad_pkg::DIST_W;

   logic signed [GW-1:0]      gap_up;
   logic signed [GW-1:0]      gap_left;
   logic signed [SCORE_W-1:0] ms;
   logic signed [SCORE_W-1:0] us;
   logic signed [SCORE_W-1:0] ls;
   logic [DW-1:0]             gc_d;

   // A gap costs the open score after a diagonal move, else the extend score.
   assign gap_up   = (up_m == gad_pkg::MV_DIAG) ? gap_open : gap_extend;
   assign gap_left = (left_m == gad_pkg::MV_DIAG) ? gap_open : gap_extend;

   assign ms = same ? (diag_s + SCORE_W'(1)) : (diag_s - SCORE_W'(1));
   assign us = up_s + {{(SCORE_W-GW){gap_up[GW-1]}}, gap_up};
   assign ls = left_s + {{(SCORE_W-GW){gap_left[GW-1]}}, gap_left};
   assign gc_d = DW'(gap_count);

   // Ties go diagonal first, then up, then left.
   always_comb begin
      if (ms >= ls && ms >= us) begin
         new_s = ms;
         new_m = gad_pkg::MV_DIAG;
         new_d = diag_d + DW'(!same);
      end else if (us >= ls) begin
         new_s = us;
         new_m = gad_pkg::MV_UP;
         new_d = up_d + gc_d;
      end else begin
         new_s = ls;
         new_m = gad_pkg::MV_LEFT;
         new_d = left_d + gc_d;
      end
   end

endmodule

@@ hdl/gad_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Global alignment distance: row engine
// Holds the reference and the current matrix row in memories and sweeps the
// row once per query symbol, one cell per cycle.
// ----------------------------------------------------------------------------
module gad_engine #(
   parameter int MAX_LEN = gad_pkg::MAX_LEN_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  gad_pkg::cfg_type            cfg,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_command,
   input  logic [gad_pkg::SYM_W-1:0]   req_symbol,
   input  logic                        req_last,
   output gad_pkg::result_type         res,
   input  logic                        res_ready
);

   localparam int LEN_W   = $clog2(MAX_LEN + 1);
   localparam int J_W     = $clog2(MAX_LEN + 2);
   localparam int RA_W    = $clog2(MAX_LEN);
   localparam int SCORE_W = $clog2(MAX_LEN) + 10;
   localparam int DW      = gad_pkg::DIST_W;
   localparam int SW      = gad_pkg::SYM_W;
   localparam int ENT_W   = SCORE_W + 2 + DW;
   localparam logic [LEN_W-1:0] MAX_LEN_V = LEN_W'(MAX_LEN);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_ROW    = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   // Memories.
   logic [SW-1:0]    ref_mem [MAX_LEN];
   logic [ENT_W-1:0] row_mem [MAX_LEN+1];
   logic [SW-1:0]    ref_rd_ff;
   logic [ENT_W-1:0] row_rd_ff;
   logic             ref_we;
   logic [RA_W-1:0]  ref_wa;
   logic [RA_W-1:0]  ref_ra;
   logic             row_we;
   logic [LEN_W-1:0] row_wa;
   logic [LEN_W-1:0] row_ra;
   logic [ENT_W-1:0] row_wd;

   // Control state.
   logic [1:0]       state_ff, state_in;
   logic [LEN_W-1:0] ref_len_ff, ref_len_in;
   logic             ref_over_ff, ref_over_in;
   logic             ref_closed_ff, ref_closed_in;
   logic [LEN_W-1:0] qidx_ff, qidx_in;
   logic             qovf_ff, qovf_in;
   logic [J_W-1:0]   j_ff, j_in;
   logic             rd_vld_ff, rd_vld_in;

   // Row sweep payload.
   logic [SW-1:0]             sym_ff, sym_in;
   logic                      last_ff, last_in;
   logic                      first_ff, first_in;
   logic [LEN_W-1:0]          cell_j_ff, cell_j_in;
   logic signed [SCORE_W-1:0] diag_s_ff, diag_s_in;
   logic [DW-1:0]             diag_d_ff, diag_d_in;
   logic signed [SCORE_W-1:0] left_s_ff, left_s_in;
   logic [1:0]                left_m_ff, left_m_in;
   logic [DW-1:0]             left_d_ff, left_d_in;
   logic [DW-1:0]             final_dist_ff, final_dist_in;

   // Cell datapath.
   logic [LEN_W-1:0]          len_eff;
   logic signed [SCORE_W-1:0] m_s, up_s, cj_s, ri_s, c_s, n_s;
   logic [1:0]                m_m, up_m, c_m, n_m;
   logic [DW-1:0]             m_d, up_d, cj_d, ri_d, c_d, n_d;
   logic                      same;
   logic                      gap_count;
   logic                      accept;

   always_ff @(posedge clock) begin
      if (ref_we) begin
         ref_mem[ref_wa] <= req_symbol;
      end
      ref_rd_ff <= ref_mem[ref_ra];
   end

   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem[row_wa] <= row_wd;
      end
      row_rd_ff <= row_mem[row_ra];
   end

   // Unpack the entry read back and form the boundary values.
   assign m_s  = row_rd_ff[ENT_W-1 -: SCORE_W];
   assign m_m  = row_rd_ff[DW+1:DW];
   assign m_d  = row_rd_ff[DW-1:0];
   assign cj_s = SCORE_W'(cell_j_ff);
   assign cj_d = DW'(cell_j_ff);
   assign ri_s = SCORE_W'(qidx_ff);
   assign ri_d = DW'(qidx_ff);

   // The first row of a query comes from the boundary, not from memory.
   assign up_s = first_ff ? -cj_s : m_s;
   assign up_m = first_ff ? gad_pkg::MV_LEFT : m_m;
   assign up_d = first_ff ? (cfg.no_end_gap ? '0 : cj_d) : m_d;

   assign same      = (ref_rd_ff == sym_ff);
   assign gap_count = !cfg.no_end_gap || (!last_ff && cell_j_ff != ref_len_ff);

   gad_cell #(
      .SCORE_W (SCORE_W)
   ) u_cell (
      .diag_s     (diag_s_ff),
      .diag_d     (diag_d_ff),
      .up_s       (up_s),
      .up_m       (up_m),
      .up_d       (up_d),
      .left_s     (left_s_ff),
      .left_m     (left_m_ff),
      .left_d     (left_d_ff),
      .same       (same),
      .gap_count  (gap_count),
      .gap_open   (cfg.gap_open),
      .gap_extend (cfg.gap_extend),
      .new_s      (c_s),
      .new_m      (c_m),
      .new_d      (c_d)
   );

   // Column zero is the boundary of the new row.
   always_comb begin
      if (cell_j_ff == '0) begin
         n_s = -ri_s;
         n_m = gad_pkg::MV_UP;
         n_d = cfg.no_end_gap ? '0 : ri_d;
      end else begin
         n_s = c_s;
         n_m = c_m;
         n_d = c_d;
      end
   end

   assign req_ready    = (state_ff == ST_IDLE);
   assign accept       = req_valid && req_ready;
   assign len_eff      = ref_closed_ff ? '0 : ref_len_ff;
   assign res.valid    = (state_ff == ST_FINISH);
   assign res.distance = final_dist_ff;
   assign res.overflow = qovf_ff | ref_over_ff;

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      ref_len_in    = ref_len_ff;
      ref_over_in   = ref_over_ff;
      ref_closed_in = ref_closed_ff;
      qidx_in       = qidx_ff;
      qovf_in       = qovf_ff;
      j_in          = j_ff;
      rd_vld_in     = 1'b0;
      sym_in        = sym_ff;
      last_in       = last_ff;
      first_in      = first_ff;
      cell_j_in     = cell_j_ff;
      diag_s_in     = diag_s_ff;
      diag_d_in     = diag_d_ff;
      left_s_in     = left_s_ff;
      left_m_in     = left_m_ff;
      left_d_in     = left_d_ff;
      final_dist_in = final_dist_ff;
      ref_we        = 1'b0;
      ref_wa        = len_eff[RA_W-1:0];
      ref_ra        = RA_W'(j_ff - J_W'(1));
      row_we        = 1'b0;
      row_wa        = cell_j_ff;
      row_ra        = j_ff[LEN_W-1:0];
      row_wd        = {n_s, n_m, n_d};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_command == gad_pkg::CMD_LOAD) begin
                  // A load after a closed reference starts a new one.
                  qidx_in       = '0;
                  qovf_in       = 1'b0;
                  ref_closed_in = req_last;
                  ref_over_in   = ref_closed_ff ? 1'b0 : ref_over_ff;
                  if (len_eff < MAX_LEN_V) begin
                     ref_we     = 1'b1;
                     ref_len_in = len_eff + LEN_W'(1);
                  end else begin
                     ref_len_in  = len_eff;
                     ref_over_in = 1'b1;
                  end
               end else begin
                  sym_in  = req_symbol;
                  last_in = req_last;
                  if (qidx_ff < MAX_LEN_V) begin
                     qidx_in  = qidx_ff + LEN_W'(1);
                     first_in = (qidx_ff == '0);
                     j_in     = '0;
                     state_in = ST_ROW;
                  end else begin
                     // Query too long: no row update, distance of the last row.
                     qovf_in = 1'b1;
                     if (req_last) begin
                        state_in = ST_FINISH;
                     end
                  end
               end
            end
         end

         ST_ROW: begin
            // Issue the reads for the next cell.
            if (j_ff <= J_W'(ref_len_ff)) begin
               rd_vld_in = 1'b1;
               cell_j_in = j_ff[LEN_W-1:0];
               j_in      = j_ff + J_W'(1);
            end
            // Finish the cell whose data came back and write it.
            if (rd_vld_ff) begin
               row_we    = 1'b1;
               diag_s_in = up_s;
               diag_d_in = up_d;
               left_s_in = n_s;
               left_m_in = n_m;
               left_d_in = n_d;
               if (cell_j_ff == ref_len_ff) begin
                  final_dist_in = n_d;
                  state_in      = last_ff ? ST_FINISH : ST_IDLE;
               end
            end
         end

         ST_FINISH: begin
            if (res_ready) begin
               qidx_in  = '0;
               qovf_in  = 1'b0;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ref_len_ff    <= '0;
         ref_over_ff   <= 1'b0;
         ref_closed_ff <= 1'b0;
         qidx_ff       <= '0;
         qovf_ff       <= 1'b0;
         j_ff          <= '0;
         rd_vld_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ref_len_ff    <= ref_len_in;
         ref_over_ff   <= ref_over_in;
         ref_closed_ff <= ref_closed_in;
         qidx_ff       <= qidx_in;
         qovf_ff       <= qovf_in;
         j_ff          <= j_in;
         rd_vld_ff     <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff        <= sym_in;
      last_ff       <= last_in;
      first_ff      <= first_in;
      cell_j_ff     <= cell_j_in;
      diag_s_ff     <= diag_s_in;
      diag_d_ff     <= diag_d_in;
      left_s_ff     <= left_s_in;
      left_m_ff     <= left_m_in;
      left_d_ff     <= left_d_in;
      final_dist_ff <= final_dist_in;
   end

endmodule

@@ hdl/global_alignment_distance_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Global alignment distance core
// Loads a reference sequence, then aligns a query against it one matrix row
// per query symbol and reports the edit distance along the chosen path.
//
// Input channel req_: each beat carries a byte symbol in tdata, the command
// in tuser (load reference symbol or process query symbol) and tlast on the
// final symbol of a reference or of a query. Result channel rsp_: one beat
// per query, after its tlast symbol, with the distance and an overflow flag.
// Configuration (end-gap mode, gap open and extend scores) is to be written
// over the csr_ APB port only while no query is in progress; the core itself
// does not enforce this. A query beat holds off further beats until its row
// sweep, which reads, updates and writes back one row memory cell per cycle,
// has covered the reference. Load beats do not hold off further beats; the
// result of a query is valid once the sweep of its last row has ended.
// Reset restores the default configuration and clears the reference length
// and the query position; the memories need no clearing. If rsp_tready is low,
// the result waits in the output register and new beats are still accepted; a
// further result holds the core until the register is free.
// ----------------------------------------------------------------------------
module global_alignment_distance_core #(
   parameter int MAX_LEN = gad_pkg::MAX_LEN_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   // Input beats.
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,   // [7:0] symbol
   input  logic                       req_tuser,   // [0] command
   input  logic                       req_tlast,
   // Result beats.
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [15:0]                rsp_tdata,   // [9:0] distance, [15:10] zero
   output logic                       rsp_tuser,   // [0] overflow
   // Configuration port.
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [gad_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [gad_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [gad_pkg::CSR_DW-1:0] csr_prdata,
   output logic                       csr_pready
);

   gad_pkg::cfg_type    cfg;
   gad_pkg::result_type res;
   logic                res_ready;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [gad_pkg::DIST_W-1:0]  rsp_dist_ff, rsp_dist_in;
   logic                        rsp_ovf_ff, rsp_ovf_in;

   gad_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   gad_engine #(
      .MAX_LEN (MAX_LEN)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_command (req_tuser),
      .req_symbol  (req_tdata),
      .req_last    (req_tlast),
      .res         (res),
      .res_ready   (res_ready)
   );

   // Output register: takes a result whenever it is empty or being drained.
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_dist_in  = rsp_dist_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (res.valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_dist_in  = res.distance;
         rsp_ovf_in   = res.overflow;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_dist_ff <= rsp_dist_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(16-gad_pkg::DIST_W){1'b0}}, rsp_dist_ff};
   assign rsp_tuser  = rsp_ovf_ff;

endmodule
